// ===== design/piddim_pkg.sv =====
// ----------------------------------------------------------------------------
// piddim_pkg
// Shared widths, fixed-point constants and register indexes of the PID dimmer.
// ----------------------------------------------------------------------------
package piddim_pkg;

    // Sensor sample and error widths
    localparam int SAMPLE_BITS = 10;
    localparam int ERR_BITS    = SAMPLE_BITS + 1;

    // Register field widths
    localparam int GAIN_BITS   = 16;
    localparam int POLE_BITS   = 13;
    localparam int LIMIT_BITS  = 16;
    localparam int DUTY_BITS   = 8;

    // Q16.8 terms and the wide working width for sums before saturation
    localparam int TERM_BITS   = 24;
    localparam int FRAC_BITS   = 8;
    localparam int WIDE_BITS   = 40;

    // Shifts that bring products back to Q.8
    localparam int GAIN_SHIFT  = 4;
    localparam int POLE_SHIFT  = 12;

    // APB port
    localparam int APB_DATA_BITS = 32;
    localparam int REG_COUNT     = 8;
    localparam int REG_IDX_BITS  = $clog2(REG_COUNT);
    localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;

    // Register map, in word order
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FEEDBACK_ENABLE  = 3'd0,
        REG_SETPOINT         = 3'd1,
        REG_FEEDFORWARD_DUTY = 3'd2,
        REG_PROPORTIONAL_GAIN = 3'd3,
        REG_INTEGRAL_COEF    = 3'd4,
        REG_DERIV_POLE_COEF  = 3'd5,
        REG_DERIV_GAIN_COEF  = 3'd6,
        REG_INTEGRAL_LIMITS  = 3'd7
    } reg_index_t;

endpackage

// ===== design/piddim_sample_if.sv =====
// ----------------------------------------------------------------------------
// piddim_sample_if
// Valid/ready channel that carries one light-sensor sample per request.
// ----------------------------------------------------------------------------
interface piddim_sample_if;
    logic                                valid;
    logic                                ready;
    logic [piddim_pkg::SAMPLE_BITS-1:0]  measured_sample;

    modport source (output valid, output measured_sample, input ready);
    modport sink   (input valid, input measured_sample, output ready);
endinterface

// ===== design/piddim_duty_if.sv =====
// ----------------------------------------------------------------------------
// piddim_duty_if
// Valid/ready channel that carries one PWM duty value per request.
// ----------------------------------------------------------------------------
interface piddim_duty_if;
    logic                              valid;
    logic                              ready;
    logic [piddim_pkg::DUTY_BITS-1:0]  duty;

    modport source (output valid, output duty, input ready);
    modport sink   (input valid, input duty, output ready);
endinterface

// ===== design/pid_dimmer_with_feedforward_core.sv =====
// ----------------------------------------------------------------------------
// pid_dimmer_with_feedforward_core
// PID light dimmer with Tustin integral, filtered derivative and feedforward.
// ----------------------------------------------------------------------------
// Usage:
//   sample_in  carries one sensor reading per request; duty_out returns one
//   saturated PWM duty (0..255) per sample, in order. Both are valid/ready.
//   The APB port programs the eight control registers at byte address 4*i;
//   write them only while no sample is in flight. pready is always high.
//
// Flow:
//   A sample accepted into the input register has its duty computed in one
//   pass and captured in the result register when it advances, then shown
//   on duty_out. While duty_out is not stalled, one sample is taken every
//   cycle; the controller state (integral, derivative, last sample, last
//   error) is updated in that same pass, which sets the rate.
//
// Reset:
//   rst_n clears the pipeline, the controller state and all registers
//   (feedback_enable comes up as 1).
//
// Stall:
//   When duty_out is not taken, the result holds and the input register
//   keeps one further sample; sample_in.ready drops until duty_out drains.
// ----------------------------------------------------------------------------
module pid_dimmer_with_feedforward_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    piddim_sample_if.sink                        sample_in,
    piddim_duty_if.source                        duty_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [piddim_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [piddim_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [piddim_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                 pready
);
    import piddim_pkg::*;

    localparam logic signed [WIDE_BITS-1:0] TERM_MAX = WIDE_BITS'((1 << (TERM_BITS - 1)) - 1);
    localparam logic signed [WIDE_BITS-1:0] TERM_MIN = -WIDE_BITS'(1 << (TERM_BITS - 1));
    localparam logic signed [WIDE_BITS-1:0] DUTY_MAX = WIDE_BITS'((1 << DUTY_BITS) - 1);
    localparam logic signed [WIDE_BITS-1:0] GAIN_HALF = WIDE_BITS'(1 << (GAIN_SHIFT - 1));
    localparam logic signed [WIDE_BITS-1:0] POLE_HALF = WIDE_BITS'(1 << (POLE_SHIFT - 1));

    // Saturate a wide value to the signed term range
    function automatic logic signed [TERM_BITS-1:0] sat_term(
        input logic signed [WIDE_BITS-1:0] x
    );
        logic signed [TERM_BITS-1:0] r;
        if (x > TERM_MAX)
            r = TERM_MAX[TERM_BITS-1:0];
        else if (x < TERM_MIN)
            r = TERM_MIN[TERM_BITS-1:0];
        else
            r = x[TERM_BITS-1:0];
        return r;
    endfunction

    // Round to nearest, ties toward plus infinity, then floor shift
    function automatic logic signed [WIDE_BITS-1:0] round_gain(
        input logic signed [WIDE_BITS-1:0] x
    );
        logic signed [WIDE_BITS-1:0] s;
        s = x + GAIN_HALF;
        return s >>> GAIN_SHIFT;
    endfunction

    function automatic logic signed [WIDE_BITS-1:0] round_pole(
        input logic signed [WIDE_BITS-1:0] x
    );
        logic signed [WIDE_BITS-1:0] s;
        s = x + POLE_HALF;
        return s >>> POLE_SHIFT;
    endfunction

    // Control registers
    logic                         feedback_enable_reg;
    logic [SAMPLE_BITS-1:0]       setpoint_reg;
    logic [DUTY_BITS-1:0]         feedforward_duty_reg;
    logic signed [GAIN_BITS-1:0]  proportional_gain_reg;
    logic signed [GAIN_BITS-1:0]  integral_coef_reg;
    logic [POLE_BITS-1:0]         deriv_pole_coef_reg;
    logic signed [GAIN_BITS-1:0]  deriv_gain_coef_reg;
    logic [2*LIMIT_BITS-1:0]      integral_limits_reg;

    // Controller state
    logic [SAMPLE_BITS-1:0]       previous_sample_reg;
    logic [SAMPLE_BITS-1:0]       previous_sample_next;
    logic signed [TERM_BITS-1:0]  integral_acc_reg;
    logic signed [TERM_BITS-1:0]  integral_acc_next;
    logic signed [TERM_BITS-1:0]  derivative_acc_reg;
    logic signed [TERM_BITS-1:0]  derivative_acc_next;
    logic signed [ERR_BITS-1:0]   previous_error_reg;
    logic signed [ERR_BITS-1:0]   previous_error_next;

    // Pipeline registers
    logic                         in_valid_reg;
    logic [SAMPLE_BITS-1:0]       in_sample_reg;
    logic                         out_valid_reg;
    logic [DUTY_BITS-1:0]         out_duty_reg;
    logic [DUTY_BITS-1:0]         out_duty_next;

    logic                         advance;
    logic                         wr_en;
    reg_index_t                   wr_idx;
    reg_index_t                   rd_idx;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
    assign rd_idx = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feedback_enable_reg   <= 1'b1;
            setpoint_reg          <= '0;
            feedforward_duty_reg  <= '0;
            proportional_gain_reg <= '0;
            integral_coef_reg     <= '0;
            deriv_pole_coef_reg   <= '0;
            deriv_gain_coef_reg   <= '0;
            integral_limits_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_FEEDBACK_ENABLE:   feedback_enable_reg   <= pwdata[0];
                REG_SETPOINT:          setpoint_reg          <= pwdata[SAMPLE_BITS-1:0];
                REG_FEEDFORWARD_DUTY:  feedforward_duty_reg  <= pwdata[DUTY_BITS-1:0];
                REG_PROPORTIONAL_GAIN: proportional_gain_reg <= $signed(pwdata[GAIN_BITS-1:0]);
                REG_INTEGRAL_COEF:     integral_coef_reg     <= $signed(pwdata[GAIN_BITS-1:0]);
                REG_DERIV_POLE_COEF:   deriv_pole_coef_reg   <= pwdata[POLE_BITS-1:0];
                REG_DERIV_GAIN_COEF:   deriv_gain_coef_reg   <= $signed(pwdata[GAIN_BITS-1:0]);
                REG_INTEGRAL_LIMITS:   integral_limits_reg   <= pwdata[2*LIMIT_BITS-1:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (rd_idx)
            REG_FEEDBACK_ENABLE:   prdata = APB_DATA_BITS'(feedback_enable_reg);
            REG_SETPOINT:          prdata = APB_DATA_BITS'(setpoint_reg);
            REG_FEEDFORWARD_DUTY:  prdata = APB_DATA_BITS'(feedforward_duty_reg);
            REG_PROPORTIONAL_GAIN: prdata = APB_DATA_BITS'($unsigned(proportional_gain_reg));
            REG_INTEGRAL_COEF:     prdata = APB_DATA_BITS'($unsigned(integral_coef_reg));
            REG_DERIV_POLE_COEF:   prdata = APB_DATA_BITS'(deriv_pole_coef_reg);
            REG_DERIV_GAIN_COEF:   prdata = APB_DATA_BITS'($unsigned(deriv_gain_coef_reg));
            REG_INTEGRAL_LIMITS:   prdata = APB_DATA_BITS'(integral_limits_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: advance the input register into the result register
    // ------------------------------------------------------------------
    assign advance         = in_valid_reg && (!out_valid_reg || duty_out.ready);
    assign sample_in.ready = !in_valid_reg || advance;
    assign duty_out.valid  = out_valid_reg;
    assign duty_out.duty   = out_duty_reg;

    // ------------------------------------------------------------------
    // PID datapath
    // ------------------------------------------------------------------
    logic signed [ERR_BITS-1:0]            sample_s;
    logic signed [ERR_BITS-1:0]            target_s;
    logic signed [ERR_BITS-1:0]            err;
    logic signed [ERR_BITS:0]              err_sum;
    logic signed [ERR_BITS-1:0]            sample_diff;
    logic signed [GAIN_BITS+ERR_BITS-1:0]  p_prod;
    logic signed [GAIN_BITS+ERR_BITS:0]    i_prod;
    logic signed [GAIN_BITS+ERR_BITS-1:0]  kg_prod;
    logic signed [POLE_BITS+TERM_BITS:0]   pole_prod;
    logic signed [TERM_BITS-1:0]           p_term;
    logic signed [TERM_BITS-1:0]           i_sat;
    logic signed [TERM_BITS-1:0]           i_term;
    logic signed [TERM_BITS-1:0]           d_term;
    logic signed [TERM_BITS-1:0]           lim_lo;
    logic signed [TERM_BITS-1:0]           lim_hi;
    logic signed [WIDE_BITS-1:0]           total;
    logic signed [WIDE_BITS-1:0]           total_int;

    assign sample_s    = $signed({1'b0, in_sample_reg});
    assign target_s    = $signed({1'b0, setpoint_reg});
    assign err         = target_s - sample_s;
    assign err_sum     = (ERR_BITS+1)'(err) + (ERR_BITS+1)'(previous_error_reg);
    assign sample_diff = sample_s - $signed({1'b0, previous_sample_reg});

    // Independent products of the three terms
    assign p_prod    = (GAIN_BITS+ERR_BITS)'(proportional_gain_reg)
                       * (GAIN_BITS+ERR_BITS)'(err);
    assign i_prod    = (GAIN_BITS+ERR_BITS+1)'(integral_coef_reg)
                       * (GAIN_BITS+ERR_BITS+1)'(err_sum);
    assign kg_prod   = (GAIN_BITS+ERR_BITS)'(deriv_gain_coef_reg)
                       * (GAIN_BITS+ERR_BITS)'(sample_diff);
    assign pole_prod = (POLE_BITS+TERM_BITS+1)'($signed({1'b0, deriv_pole_coef_reg}))
                       * (POLE_BITS+TERM_BITS+1)'(derivative_acc_reg);

    // Integral limits in Q16.8
    assign lim_lo = $signed({integral_limits_reg[LIMIT_BITS-1:0], FRAC_BITS'(0)});
    assign lim_hi = $signed({integral_limits_reg[2*LIMIT_BITS-1:LIMIT_BITS], FRAC_BITS'(0)});

    // Terms, clamp and sum
    always_comb
    begin
        p_term = sat_term(round_gain(WIDE_BITS'(p_prod)));
        i_sat  = sat_term(WIDE_BITS'(integral_acc_reg) + round_gain(WIDE_BITS'(i_prod)));
        priority if (i_sat > lim_hi)
            i_term = lim_hi;
        else if (i_sat < lim_lo)
            i_term = lim_lo;
        else
            i_term = i_sat;
        d_term = sat_term(round_pole(WIDE_BITS'(pole_prod))
                          - round_gain(WIDE_BITS'(kg_prod)));

        total = WIDE_BITS'($signed({1'b0, feedforward_duty_reg, FRAC_BITS'(0)}));
        if (feedback_enable_reg)
            total = total + WIDE_BITS'(p_term) + WIDE_BITS'(i_term) + WIDE_BITS'(d_term);
        total_int = total >>> FRAC_BITS;

        priority if (total_int > DUTY_MAX)
            out_duty_next = DUTY_MAX[DUTY_BITS-1:0];
        else if (total_int < 0)
            out_duty_next = '0;
        else
            out_duty_next = total_int[DUTY_BITS-1:0];

        // Hold the integral, derivative and last error while feedback is off; the last sample always follows
        previous_sample_next = in_sample_reg;
        if (feedback_enable_reg)
        begin
            integral_acc_next   = i_term;
            derivative_acc_next = d_term;
            previous_error_next = err;
        end
        else
        begin
            integral_acc_next   = integral_acc_reg;
            derivative_acc_next = derivative_acc_reg;
            previous_error_next = previous_error_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_in.ready)
                in_valid_reg <= sample_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (duty_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
            in_sample_reg <= sample_in.measured_sample;
        if (advance)
            out_duty_reg <= out_duty_next;
    end

    // Update the controller state once per computed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_sample_reg <= '0;
            integral_acc_reg    <= '0;
            derivative_acc_reg  <= '0;
            previous_error_reg  <= '0;
        end
        else if (advance)
        begin
            previous_sample_reg <= previous_sample_next;
            integral_acc_reg    <= integral_acc_next;
            derivative_acc_reg  <= derivative_acc_next;
            previous_error_reg  <= previous_error_next;
        end
    end

endmodule

// ===== design/piddim_checker.sv =====
// ----------------------------------------------------------------------------
// piddim_port_checker
// Port-level checks of the PID dimmer, bound to the top level.
// ----------------------------------------------------------------------------
module piddim_port_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [piddim_pkg::DUTY_BITS-1:0]    duty,
    input logic                                pready
);
    import piddim_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty))
        else $error("duty_out dropped or changed while stalled");

    // Show a result after a sample request is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("no result after accepted sample");

    // Refuse samples only while a result is stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("sample_in stalled without output stall");

    // Keep the register port ready
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind pid_dimmer_with_feedforward_core piddim_port_checker u_piddim_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (duty_out.valid),
    .out_ready (duty_out.ready),
    .duty      (duty_out.duty),
    .pready    (pready)
);
